[hw/rtl/csm_pkg.sv]
// Shared types and constants for the canard servo mixer with fin smoothing.
package csm_pkg;

  // Fixed-point formats.
  localparam int unsigned ANGLE_FRAC_BITS = 8;
  localparam int unsigned ALPHA_FRAC_BITS = 16;
  localparam int unsigned IN_W            = 17;
  localparam int unsigned ANGLE_W         = 16;
  localparam int unsigned ALPHA_W         = 17;
  localparam int unsigned DEFL_W          = 7;
  localparam int unsigned PULSE_W         = 12;
  localparam int unsigned NUM_FINS        = 4;
  localparam int unsigned FIN_W           = 2;
  localparam int unsigned BIT_CNT_W       = 5;

  // Angles and limits.
  localparam logic [DEFL_W-1:0]  DEFL_LIMIT_DEG = DEFL_W'(90);
  localparam logic [DEFL_W-1:0]  DEFL_RESET     = DEFL_W'(45);
  localparam logic [ANGLE_W-1:0] CENTER_ANGLE   = ANGLE_W'(90 << ANGLE_FRAC_BITS);
  localparam logic [ANGLE_W-1:0] FULL_ANGLE     = ANGLE_W'(180 << ANGLE_FRAC_BITS);

  // Filter weight.
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE   = ALPHA_W'(1 << ALPHA_FRAC_BITS);
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET = ALPHA_W'(19661);
  localparam logic [BIT_CNT_W-1:0] ALPHA_LAST  = BIT_CNT_W'(ALPHA_W - 1);

  // Pulse scaling: pulse = 500 + floor(angle * 2000 / 46080)
  //                      = 500 + floor(floor(angle * 25 / 64) / 9).
  // The divide by nine is a reciprocal multiply, exact for the range in use.
  localparam int unsigned        SCALE_SHIFT = 6;
  localparam int unsigned        Y_W         = 15;
  localparam logic [12:0]        RECIP_NINE  = 13'd7282;
  localparam int unsigned        RECIP_SHIFT = 16;
  localparam logic [PULSE_W-1:0] PULSE_MIN   = PULSE_W'(500);
  localparam logic [PULSE_W-1:0] PULSE_MAX   = PULSE_W'(2500);

  // Register indexes on the configuration port.
  localparam logic REG_MAX_DEFLECTION = 1'b0;
  localparam logic REG_FILTER_ALPHA   = 1'b1;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_PULSE = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

  typedef logic [ANGLE_W-1:0] angle_t;
  typedef logic [PULSE_W-1:0] pulse_t;

endpackage

[hw/rtl/canard_servo_mixer_lpf_core.sv]
// Top level of the canard servo mixer with per-fin first-order smoothing.
//
// Usage: the input channel carries one pitch and one roll correction (signed
// degrees with eight fraction bits) per transfer. Each is clamped to plus or
// minus the configured deflection limit and mirrored about 90 degrees into four
// fin targets, which pass through their own low-pass filters. The result
// channel carries one transfer of four servo pulse compare values per input.
// An input transfer is taken only while the sequencer is idle; the four fins
// are then processed one after another. Each fin runs through the
// bit-serial multiplier (one bit of the filter weight per cycle), then the
// state update and the two pulse scaling steps (ST_UPD, ST_SCALE, ST_PULSE);
// after the last fin ST_FIN hands the result over and the sequencer returns
// to idle, so a new item is taken only once the previous one is through.
// The result sits in an output register, so the next item is accepted
// while a finished result still waits; if the receiver stalls for longer, the
// sequencer holds its finished result until the output register is free.
// Reset sets the deflection limit to 45 degrees, the weight to 19661/65536 and
// all four filter states to 90 degrees, and leaves no result pending.
// Configuration writes are taken in any cycle and should be made while idle.
module canard_servo_mixer_lpf_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration write port
  input  logic                                  cfg_we_i,
  input  logic                                  cfg_idx_i,
  input  logic [csm_pkg::ALPHA_W-1:0]           cfg_wdata_i,
  // input channel
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [csm_pkg::IN_W-1:0]       pitch_angle_i,
  input  logic signed [csm_pkg::IN_W-1:0]       roll_angle_i,
  // result channel
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [csm_pkg::PULSE_W-1:0]           pulse_pitch_minus_o,
  output logic [csm_pkg::PULSE_W-1:0]           pulse_roll_minus_o,
  output logic [csm_pkg::PULSE_W-1:0]           pulse_pitch_plus_o,
  output logic [csm_pkg::PULSE_W-1:0]           pulse_roll_plus_o
);

  // Configuration registers.
  logic [csm_pkg::DEFL_W-1:0]  max_defl_q;
  logic [csm_pkg::ALPHA_W-1:0] alpha_q;

  // Sequencer.
  csm_pkg::state_e               state_q, state_d;
  logic [csm_pkg::FIN_W-1:0]     fin_q, fin_d;
  logic [csm_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;

  // Per-fin storage: targets of the current item, filter states, pulses.
  csm_pkg::angle_t tgt_q   [csm_pkg::NUM_FINS];
  csm_pkg::angle_t angle_q [csm_pkg::NUM_FINS];
  csm_pkg::pulse_t pulse_q [csm_pkg::NUM_FINS];

  // Bit-serial multiplier: weight shift register and product halves.
  logic [csm_pkg::ALPHA_W-1:0] alpha_sr_q, alpha_sr_d;
  logic [17:0]                 hi_q, hi_d;
  logic [16:0]                 lo_q, lo_d;

  // Scaling register between the two pulse steps.
  logic [csm_pkg::Y_W-1:0] y_q, y_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  csm_pkg::pulse_t out_pulse_q [csm_pkg::NUM_FINS];

  logic in_xfer, out_free, load_out;

  assign in_xfer  = in_valid_i && (state_q == csm_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == csm_pkg::ST_FIN) && out_free;

  // ---------------------------------------------------------------------
  // Clamp and mirror. The limit saturates at 90 degrees.
  // ---------------------------------------------------------------------
  logic [csm_pkg::DEFL_W-1:0] lim_deg;
  logic signed [17:0]         lim_s, pitch_c, roll_c;
  logic signed [17:0]         tgt_s [csm_pkg::NUM_FINS];

  function automatic logic signed [17:0] clamp_angle(input logic signed [17:0] a,
                                                     input logic signed [17:0] lim);
    logic signed [17:0] r;
    r = a;
    if (a >= lim) begin
      r = lim;
    end else if (a <= -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  always_comb begin
    lim_deg  = (max_defl_q > csm_pkg::DEFL_LIMIT_DEG) ? csm_pkg::DEFL_LIMIT_DEG : max_defl_q;
    lim_s    = $signed(18'(lim_deg) << csm_pkg::ANGLE_FRAC_BITS);
    pitch_c  = clamp_angle($signed({pitch_angle_i[csm_pkg::IN_W-1], pitch_angle_i}), lim_s);
    roll_c   = clamp_angle($signed({roll_angle_i[csm_pkg::IN_W-1], roll_angle_i}), lim_s);
    tgt_s[0] = $signed({2'b00, csm_pkg::CENTER_ANGLE}) - pitch_c;
    tgt_s[1] = $signed({2'b00, csm_pkg::CENTER_ANGLE}) - roll_c;
    tgt_s[2] = $signed({2'b00, csm_pkg::CENTER_ANGLE}) + pitch_c;
    tgt_s[3] = $signed({2'b00, csm_pkg::CENTER_ANGLE}) + roll_c;
  end

  // ---------------------------------------------------------------------
  // Filter datapath. The update is rewritten as
  //   new = old + floor((alpha * (target - old) + ONE/2) / ONE),
  // which equals the weighted sum rounded half up. The product is formed
  // one weight bit per cycle, shifting right so that the adder stays narrow.
  // ---------------------------------------------------------------------
  logic [csm_pkg::ALPHA_W-1:0] alpha_sat;
  logic signed [16:0]          diff;
  logic [18:0]                 addend, mul_sum;
  logic [17:0]                 lo_rnd;
  logic [19:0]                 delta;
  csm_pkg::angle_t             new_angle;
  logic [20:0]                 ang25;
  logic [27:0]                 recip_prod;
  logic [12:0]                 pulse_sum;
  csm_pkg::pulse_t             pulse_val;

  always_comb begin
    alpha_sat  = (alpha_q > csm_pkg::ALPHA_ONE) ? csm_pkg::ALPHA_ONE : alpha_q;
    diff       = $signed({1'b0, tgt_q[fin_q]}) - $signed({1'b0, angle_q[fin_q]});
    addend     = alpha_sr_q[0] ? {{2{diff[16]}}, diff} : '0;
    mul_sum    = {hi_q[17], hi_q} + addend;
    // Rounding: the low 17 product bits plus one half decide the carry.
    lo_rnd     = {1'b0, lo_q} + 18'h08000;
    delta      = {hi_q[17], hi_q, 1'b0} + {18'b0, lo_rnd[17:16]};
    new_angle  = angle_q[fin_q] + delta[csm_pkg::ANGLE_W-1:0];
    // angle * 25 by shifts and adds, then the divide by 64.
    ang25      = (21'(angle_q[fin_q]) << 4) + (21'(angle_q[fin_q]) << 3)
               + 21'(angle_q[fin_q]);
    y_d        = ang25[csm_pkg::SCALE_SHIFT +: csm_pkg::Y_W];
    recip_prod = {13'b0, y_q} * {15'b0, csm_pkg::RECIP_NINE};
    pulse_sum  = {1'b0, csm_pkg::PULSE_MIN}
               + {1'b0, recip_prod[csm_pkg::RECIP_SHIFT +: csm_pkg::PULSE_W]};
    pulse_val  = (pulse_sum > {1'b0, csm_pkg::PULSE_MAX}) ? csm_pkg::PULSE_MAX
               : pulse_sum[csm_pkg::PULSE_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    fin_d      = fin_q;
    bit_cnt_d  = bit_cnt_q;
    alpha_sr_d = alpha_sr_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    unique case (state_q)
      csm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d    = csm_pkg::ST_MUL;
          fin_d      = '0;
          bit_cnt_d  = '0;
          alpha_sr_d = alpha_sat;
          hi_d       = '0;
          lo_d       = '0;
        end
      end
      csm_pkg::ST_MUL: begin
        hi_d       = mul_sum[18:1];
        lo_d       = {mul_sum[0], lo_q[16:1]};
        alpha_sr_d = alpha_sr_q >> 1;
        bit_cnt_d  = bit_cnt_q + 1'b1;
        if (bit_cnt_q == csm_pkg::ALPHA_LAST) begin
          state_d = csm_pkg::ST_UPD;
        end
      end
      csm_pkg::ST_UPD: begin
        state_d = csm_pkg::ST_SCALE;
      end
      csm_pkg::ST_SCALE: begin
        state_d = csm_pkg::ST_PULSE;
      end
      csm_pkg::ST_PULSE: begin
        if (fin_q == csm_pkg::FIN_W'(csm_pkg::NUM_FINS - 1)) begin
          state_d = csm_pkg::ST_FIN;
        end else begin
          state_d    = csm_pkg::ST_MUL;
          fin_d      = fin_q + 1'b1;
          bit_cnt_d  = '0;
          alpha_sr_d = alpha_sat;
          hi_d       = '0;
          lo_d       = '0;
        end
      end
      csm_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = csm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = csm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csm_pkg::ST_IDLE;
      fin_q       <= '0;
      bit_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      max_defl_q  <= csm_pkg::DEFL_RESET;
      alpha_q     <= csm_pkg::ALPHA_RESET;
      for (int i = 0; i < csm_pkg::NUM_FINS; i++) begin
        angle_q[i] <= csm_pkg::CENTER_ANGLE;
      end
    end else begin
      state_q     <= state_d;
      fin_q       <= fin_d;
      bit_cnt_q   <= bit_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          csm_pkg::REG_MAX_DEFLECTION: max_defl_q <= cfg_wdata_i[csm_pkg::DEFL_W-1:0];
          csm_pkg::REG_FILTER_ALPHA:   alpha_q    <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == csm_pkg::ST_UPD) begin
        angle_q[fin_q] <= new_angle;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    alpha_sr_q <= alpha_sr_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    if (in_xfer) begin
      for (int i = 0; i < csm_pkg::NUM_FINS; i++) begin
        tgt_q[i] <= tgt_s[i][csm_pkg::ANGLE_W-1:0];
      end
    end
    if (state_q == csm_pkg::ST_SCALE) begin
      y_q <= y_d;
    end
    if (state_q == csm_pkg::ST_PULSE) begin
      pulse_q[fin_q] <= pulse_val;
    end
    if (load_out) begin
      for (int i = 0; i < csm_pkg::NUM_FINS; i++) begin
        out_pulse_q[i] <= pulse_q[i];
      end
    end
  end

  assign in_stall_o          = (state_q != csm_pkg::ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign pulse_pitch_minus_o = out_pulse_q[0];
  assign pulse_roll_minus_o  = out_pulse_q[1];
  assign pulse_pitch_plus_o  = out_pulse_q[2];
  assign pulse_roll_plus_o   = out_pulse_q[3];

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  // The filter states never leave 0..180 degrees.
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q[0] <= csm_pkg::FULL_ANGLE && angle_q[1] <= csm_pkg::FULL_ANGLE &&
    angle_q[2] <= csm_pkg::FULL_ANGLE && angle_q[3] <= csm_pkg::FULL_ANGLE)
    else $error("filter state out of range");

  // The multiplier leaves after exactly one pass over the weight bits.
  a_mul_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csm_pkg::ST_MUL) |-> (bit_cnt_q <= csm_pkg::ALPHA_LAST))
    else $error("multiplier ran past the last weight bit");

  // A held result is never overwritten; the pitch-minus and roll-plus pulses are checked.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_pulse_q[0])
      && $stable(out_pulse_q[3])))
    else $error("held result was overwritten");

  // The delivered roll-minus and pitch-plus pulses lie within the servo range.
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_pulse_q[1] >= csm_pkg::PULSE_MIN &&
                     out_pulse_q[1] <= csm_pkg::PULSE_MAX &&
                     out_pulse_q[2] >= csm_pkg::PULSE_MIN &&
                     out_pulse_q[2] <= csm_pkg::PULSE_MAX))
    else $error("pulse out of servo range");

endmodule

[tb/tb_canard_servo_mixer_lpf_core.sv]
// Self-checking testbench for the canard servo mixer with per-fin smoothing.
`timescale 1ns / 100ps

module tb_canard_servo_mixer_lpf_core;

  // Run control. About 520 angle pairs are sent, with random gaps, stalls
  // and one long hold-off; the cycle limit leaves a wide margin on top of that.
  localparam int unsigned LIMIT_CYCLES = 500_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES  = 700;
  localparam int unsigned BLOCKS       = 4;
  localparam int unsigned PAIRS_PER_BLOCK = 42;
  localparam int unsigned PULSE_SPAN   = 2000;

  // The four pulse compare values of one result transfer, in port order.
  typedef struct packed {
    csm_pkg::pulse_t pitch_minus;
    csm_pkg::pulse_t roll_minus;
    csm_pkg::pulse_t pitch_plus;
    csm_pkg::pulse_t roll_plus;
  } fin_pulses_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  // One line of the directed table. A register row uses reg_idx and reg_data;
  // an item row uses the angles, and where pinned is set its result is the
  // typed-in pulse set rather than the one the predictor works out.
  typedef struct packed {
    row_kind_e                       kind;
    logic                            reg_idx;
    logic [csm_pkg::ALPHA_W-1:0]     reg_data;
    logic signed [csm_pkg::IN_W-1:0] pitch;
    logic signed [csm_pkg::IN_W-1:0] roll;
    logic                            pinned;
    fin_pulses_t                     pulses;
  } directed_row_t;

  // Pulse sets that can be read straight off the scaling: 90 degrees gives
  // 1500, 0 degrees 500, 180 degrees 2500, 45 and 135 degrees 1000 and 2000.
  localparam fin_pulses_t NO_PULSES  = '0;
  localparam fin_pulses_t ALL_CENTRE = '{12'd1500, 12'd1500, 12'd1500, 12'd1500};
  localparam fin_pulses_t SWING_A    = '{12'd500, 12'd2500, 12'd2500, 12'd500};
  localparam fin_pulses_t SWING_B    = '{12'd2500, 12'd500, 12'd500, 12'd2500};
  localparam fin_pulses_t HALF_SWING = '{12'd1000, 12'd2000, 12'd2000, 12'd1000};

  localparam int unsigned DIRECTED_ROWS = 27;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Reset values: a centred input leaves the filters at 90 degrees.
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd0, 17'sd0, 1'b1, ALL_CENTRE},
    // A step at the default limit and weight shows the smoothing.
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd11520, -17'sd11520, 1'b0, NO_PULSES},
    // No smoothing and the full deflection range: the fins hit both ends.
    '{ROW_CFG, csm_pkg::REG_FILTER_ALPHA, 17'd65536, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_CFG, csm_pkg::REG_MAX_DEFLECTION, 17'd90, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd46080, -17'sd46080, 1'b1, SWING_A},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, -17'sd46080, 17'sd46080, 1'b1, SWING_B},
    // An input equal to the limit gives the limit.
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd23040, -17'sd23040, 1'b1, SWING_A},
    // A limit above 90 degrees is cut to 90; the inputs are at their widest.
    '{ROW_CFG, csm_pkg::REG_MAX_DEFLECTION, 17'd127, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd65535, 17'sh10000, 1'b1, SWING_A},
    // A zero limit puts every fin at 90 degrees.
    '{ROW_CFG, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd12345, -17'sd999, 1'b1, ALL_CENTRE},
    // A weight above one is cut to one, so the fins follow the target.
    '{ROW_CFG, csm_pkg::REG_MAX_DEFLECTION, 17'd45, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_CFG, csm_pkg::REG_FILTER_ALPHA, 17'd131071, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd65535, 17'sh10000, 1'b1, HALF_SWING},
    // A zero weight freezes the filters whatever the targets are.
    '{ROW_CFG, csm_pkg::REG_FILTER_ALPHA, 17'd0, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, -17'sd46080, 17'sd46080, 1'b1, HALF_SWING},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd0, 17'sd0, 1'b1, HALF_SWING},
    // The smallest non-zero weight barely moves the fins.
    '{ROW_CFG, csm_pkg::REG_FILTER_ALPHA, 17'd1, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, -17'sd46080, 17'sd46080, 1'b0, NO_PULSES},
    // Half weight, a one-degree limit and inputs around one LSB and one degree.
    '{ROW_CFG, csm_pkg::REG_FILTER_ALPHA, 17'd32768, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_CFG, csm_pkg::REG_MAX_DEFLECTION, 17'd1, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd1, -17'sd1, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd256, -17'sd257, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, -17'sd256, 17'sd255, 1'b0, NO_PULSES},
    '{ROW_CFG, csm_pkg::REG_MAX_DEFLECTION, 17'd90, 17'sd0, 17'sd0, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, 17'sd30000, -17'sd12345, 1'b0, NO_PULSES},
    '{ROW_ITEM, csm_pkg::REG_MAX_DEFLECTION, 17'd0, -17'sd1, 17'sd0, 1'b0, NO_PULSES}
  };

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  // Block inputs, all known from time zero.
  logic                            cfg_we_i      = 1'b0;
  logic                            cfg_idx_i     = csm_pkg::REG_MAX_DEFLECTION;
  logic [csm_pkg::ALPHA_W-1:0]     cfg_wdata_i   = '0;
  logic                            in_valid_i    = 1'b0;
  logic signed [csm_pkg::IN_W-1:0] pitch_angle_i = '0;
  logic signed [csm_pkg::IN_W-1:0] roll_angle_i  = '0;
  logic                            out_stall_i   = 1'b0;

  logic            in_stall_o;
  logic            out_valid_o;
  csm_pkg::pulse_t pulse_pitch_minus_o;
  csm_pkg::pulse_t pulse_roll_minus_o;
  csm_pkg::pulse_t pulse_pitch_plus_o;
  csm_pkg::pulse_t pulse_roll_plus_o;

  canard_servo_mixer_lpf_core uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .pitch_angle_i       (pitch_angle_i),
    .roll_angle_i        (roll_angle_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .pulse_pitch_minus_o (pulse_pitch_minus_o),
    .pulse_roll_minus_o  (pulse_roll_minus_o),
    .pulse_pitch_plus_o  (pulse_pitch_plus_o),
    .pulse_roll_plus_o   (pulse_roll_plus_o)
  );

  // Our own copy of the block's registers and filter states, used to work
  // out the pulse set that each accepted angle pair should produce.
  logic [csm_pkg::DEFL_W-1:0]  defl_limit_deg = csm_pkg::DEFL_RESET;
  logic [csm_pkg::ALPHA_W-1:0] smooth_weight  = csm_pkg::ALPHA_RESET;
  csm_pkg::angle_t             fin_angle [4]  = '{csm_pkg::CENTER_ANGLE,
                                                  csm_pkg::CENTER_ANGLE,
                                                  csm_pkg::CENTER_ANGLE,
                                                  csm_pkg::CENTER_ANGLE};

  // Pulse sets still owed by the block, oldest first.
  fin_pulses_t pending_pulses [$];

  int unsigned send_idle_pct   = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;
  int unsigned pairs_sent      = 0;
  int unsigned pulse_sets_seen = 0;
  int unsigned regs_written    = 0;
  int unsigned fault_count     = 0;
  int unsigned cycle_count     = 0;

  // Clamp to plus or minus the limit; a value equal to the limit is kept.
  function automatic int clamp_angle(int value, int limit);
    if (value >= limit) return limit;
    if (value <= -limit) return -limit;
    return value;
  endfunction

  // One step of a fin's first-order filter, rounded half up. A weight above
  // one is taken as one.
  function automatic csm_pkg::angle_t smooth_fin(int unsigned fin, csm_pkg::angle_t target);
    logic [csm_pkg::ALPHA_W-1:0] weight;
    logic [47:0]                 acc;
    weight = (smooth_weight > csm_pkg::ALPHA_ONE) ? csm_pkg::ALPHA_ONE : smooth_weight;
    acc = 48'(weight) * 48'(target)
        + 48'(csm_pkg::ALPHA_ONE - weight) * 48'(fin_angle[fin])
        + 48'(csm_pkg::ALPHA_ONE >> 1);
    fin_angle[fin] = csm_pkg::angle_t'(acc >> csm_pkg::ALPHA_FRAC_BITS);
    return fin_angle[fin];
  endfunction

  // 0..180 degrees maps onto 500..2500, rounded down and kept in bounds.
  function automatic csm_pkg::pulse_t angle_to_pulse(csm_pkg::angle_t angle);
    logic [31:0] pulse;
    pulse = 32'(csm_pkg::PULSE_MIN)
          + (32'(angle) * 32'(PULSE_SPAN)) / 32'(csm_pkg::FULL_ANGLE);
    if (pulse > 32'(csm_pkg::PULSE_MAX)) pulse = 32'(csm_pkg::PULSE_MAX);
    if (pulse < 32'(csm_pkg::PULSE_MIN)) pulse = 32'(csm_pkg::PULSE_MIN);
    return csm_pkg::pulse_t'(pulse);
  endfunction

  // Mixes one pitch and roll pair into the four fins and advances the filters.
  function automatic fin_pulses_t steer_fins(logic signed [csm_pkg::IN_W-1:0] pitch,
                                             logic signed [csm_pkg::IN_W-1:0] roll);
    int          limit;
    int          centre;
    int          p;
    int          r;
    fin_pulses_t pulses;
    limit  = (defl_limit_deg > csm_pkg::DEFL_LIMIT_DEG) ? int'(csm_pkg::DEFL_LIMIT_DEG)
                                                         : int'(defl_limit_deg);
    limit  = limit << csm_pkg::ANGLE_FRAC_BITS;
    centre = int'(csm_pkg::CENTER_ANGLE);
    p = clamp_angle(int'(pitch), limit);
    r = clamp_angle(int'(roll), limit);
    pulses.pitch_minus = angle_to_pulse(smooth_fin(0, csm_pkg::angle_t'(centre - p)));
    pulses.roll_minus  = angle_to_pulse(smooth_fin(1, csm_pkg::angle_t'(centre - r)));
    pulses.pitch_plus  = angle_to_pulse(smooth_fin(2, csm_pkg::angle_t'(centre + p)));
    pulses.roll_plus   = angle_to_pulse(smooth_fin(3, csm_pkg::angle_t'(centre + r)));
    return pulses;
  endfunction

  // Random deflection limits lean towards the extremes and the saturation.
  function automatic logic [csm_pkg::ALPHA_W-1:0] pick_deflection();
    case ($urandom_range(0, 5))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd90;
      3:       return 17'd127;
      default: return 17'($urandom_range(0, 127));
    endcase
  endfunction

  // Random weights: freeze, slowest, exactly one, saturated and in between.
  function automatic logic [csm_pkg::ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 17'd0;
      1:       return 17'd1;
      2:       return 17'd65536;
      3:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(1, 65535));
    endcase
  endfunction

  // Random angles: mostly within +/-180 degrees, some right at the current
  // limit, some around zero and some over the whole 17-bit range.
  function automatic logic signed [csm_pkg::IN_W-1:0] random_angle();
    int limit;
    int value;
    limit = (defl_limit_deg > csm_pkg::DEFL_LIMIT_DEG) ? int'(csm_pkg::DEFL_LIMIT_DEG)
                                                        : int'(defl_limit_deg);
    limit = limit << csm_pkg::ANGLE_FRAC_BITS;
    case ($urandom_range(0, 9))
      0, 1:    value = int'($urandom_range(0, 131071));
      2, 3:    value = limit + int'($urandom_range(0, 6)) - 3;
      4:       value = int'($urandom_range(0, 2)) - 1;
      default: value = int'($urandom_range(0, 92160)) - 46080;
    endcase
    if ($urandom_range(0, 1) == 1) value = -value;
    return 17'(value);
  endfunction

  // Offers one angle pair, after a random gap, and holds it until the block
  // takes it. Returns at the falling edge after the transfer with valid still
  // high, so the caller either presents the next pair or drops valid there.
  task automatic offer_angles(input logic signed [csm_pkg::IN_W-1:0] pitch,
                              input logic signed [csm_pkg::IN_W-1:0] roll,
                              input logic pinned, input fin_pulses_t pinned_pulses);
    fin_pulses_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pitch_angle_i <= pitch;
    roll_angle_i  <= roll;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    predicted = steer_fins(pitch, roll);
    pending_pulses.push_back(pinned ? pinned_pulses : predicted);
    pairs_sent++;
    @(negedge clk_i);
  endtask

  // Register writes wait until every owed result has come back, so that the
  // block is idle. Every pair gives a result, so an empty queue means idle.
  task automatic write_reg(input logic idx, input logic [csm_pkg::ALPHA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_pulses.size() != 0) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == csm_pkg::REG_MAX_DEFLECTION) defl_limit_deg = data[csm_pkg::DEFL_W-1:0];
    else smooth_weight = data;
    regs_written++;
    @(negedge clk_i);
  endtask

  task automatic check_field(input string name, input csm_pkg::pulse_t want,
                             input csm_pkg::pulse_t got);
    if (want !== got) begin
      fault_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Result side: every transfer is compared with the oldest owed pulse set.
  always @(posedge clk_i) begin
    fin_pulses_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      pulse_sets_seen++;
      if (pending_pulses.size() == 0) begin
        fault_count++;
        $display("%0t: result expected none, got %0d %0d %0d %0d", $time,
                 pulse_pitch_minus_o, pulse_roll_minus_o, pulse_pitch_plus_o,
                 pulse_roll_plus_o);
      end else begin
        want = pending_pulses.pop_front();
        check_field("pulse_pitch_minus", want.pitch_minus, pulse_pitch_minus_o);
        check_field("pulse_roll_minus", want.roll_minus, pulse_roll_minus_o);
        check_field("pulse_pitch_plus", want.pitch_plus, pulse_pitch_plus_o);
        check_field("pulse_roll_plus", want.roll_plus, pulse_roll_plus_o);
      end
    end
  end

  // Receiver stalls. A requested hold-off is counted out here, cycle by
  // cycle, while the sender keeps offering pairs, so the output register and
  // the sequencer both fill and the block has to stall its input.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      holds_served <= holds_served + 1;
      hold_left    <= HOLD_CYCLES - 1;
      out_stall_i  <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d pulse sets still owed", $time,
               pending_pulses.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table, with the first idling mix.
    send_idle_pct  = 37;
    recv_stall_pct = 78;
    for (int row = 0; row < DIRECTED_ROWS; row++) begin
      if (DIRECTED[row].kind == ROW_CFG)
        write_reg(DIRECTED[row].reg_idx, DIRECTED[row].reg_data);
      else
        offer_angles(DIRECTED[row].pitch, DIRECTED[row].roll, DIRECTED[row].pinned,
                     DIRECTED[row].pulses);
    end

    // Random part in three idling mixes, with fresh settings for each block
    // of pairs. The long receiver hold-off opens the mix without gaps.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 37;
          recv_stall_pct = 78;
        end
        1: begin
          send_idle_pct  = 78;
          recv_stall_pct = 37;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < BLOCKS; blk++) begin
        write_reg(csm_pkg::REG_MAX_DEFLECTION, pick_deflection());
        write_reg(csm_pkg::REG_FILTER_ALPHA, pick_alpha());
        if (phase == 2 && blk == 0) holds_requested++;
        for (int n = 0; n < PAIRS_PER_BLOCK; n++)
          offer_angles(random_angle(), random_angle(), 1'b0, NO_PULSES);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_pulses.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d pitch/roll pairs, checked %0d pulse sets, made %0d register writes.",
             pairs_sent, pulse_sets_seen, regs_written);
    $display("Gap mixes 37/78, 78/37 and none, plus a %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (fault_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
